[src/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, command codes and the control/status bundles that join
// the controller and the datapath of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default geometry of the character cell array.
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 4;

    // Attribute after reset and the character codes with a special meaning.
    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Item command codes.
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Class of the character carried by a put item.
    typedef enum logic [2:0] {
        CHR_PLAIN,
        CHR_BS,
        CHR_TAB,
        CHR_LF,
        CHR_CR
    } t_chr_class;

    // Cursor update applied at the end of a cycle.
    typedef enum logic [2:0] {
        CUR_NONE,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_RETURN,
        CUR_BACK,
        CUR_HOME
    } t_cur_op;

    // Single cell write selection.
    typedef enum logic [1:0] {
        WR_NONE,
        WR_CHAR,
        WR_SPACE_HERE,
        WR_SPACE_PREV
    } t_wr_sel;

    // Kind of full-array sweep.
    typedef enum logic [1:0] {
        SW_INIT,
        SW_CLEAR,
        SW_SCROLL
    } t_sw_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;
        t_cur_op  cur_op;
        t_wr_sel  wr_sel;
        logic     rd_cell;
        logic     sw_start;
        t_sw_kind sw_kind;
        logic     capture;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] item_cmd;
        t_chr_class chr_class;
        logic       rd_in_range;
        logic       col_zero;
        logic       col_last;
        logic       row_last;
        logic       tab_aligned;
        logic       sweep_busy;
    } t_dp_status;

endpackage

[src/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences one item at a time: dispatch, tab fill, array sweeps for reset,
// clear and scroll, and the result transfer.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_dp_cmd    o_cmd
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_INIT     = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DISPATCH = 3'd2;
    localparam logic [2:0] ST_TAB      = 3'd3;
    localparam logic [2:0] ST_SWEEP    = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    logic [2:0] r_state, n_state;
    logic [2:0] r_after, n_after;
    logic       scroll_on_advance;

    // A printed cell at the bottom right corner pushes the array up one row.
    assign scroll_on_advance = i_status.col_last && i_status.row_last;

    // State register and the return state after a sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_after <= ST_IDLE;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
        end
    end

    assign busy = (r_state != ST_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        n_after        = r_after;
        o_cmd          = '0;
        o_cmd.cur_op   = CUR_NONE;
        o_cmd.wr_sel   = WR_NONE;
        o_cmd.sw_kind  = SW_CLEAR;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.sw_start = 1'b1;
                o_cmd.sw_kind  = SW_INIT;
                n_after        = ST_IDLE;
                n_state        = ST_SWEEP;
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_state = ST_DONE;
                unique case (i_status.item_cmd)
                    CMD_PUT: begin
                        unique case (i_status.chr_class)
                            CHR_LF: begin
                                o_cmd.cur_op = CUR_NEWLINE;
                                if (i_status.row_last) begin
                                    o_cmd.sw_start = 1'b1;
                                    o_cmd.sw_kind  = SW_SCROLL;
                                    n_after        = ST_DONE;
                                    n_state        = ST_SWEEP;
                                end
                            end
                            CHR_CR: begin
                                o_cmd.cur_op = CUR_RETURN;
                            end
                            CHR_BS: begin
                                if (!i_status.col_zero) begin
                                    o_cmd.cur_op = CUR_BACK;
                                    o_cmd.wr_sel = WR_SPACE_PREV;
                                end
                            end
                            CHR_TAB: begin
                                o_cmd.cur_op = CUR_ADVANCE;
                                o_cmd.wr_sel = WR_SPACE_HERE;
                                n_state      = ST_TAB;
                                if (scroll_on_advance) begin
                                    o_cmd.sw_start = 1'b1;
                                    o_cmd.sw_kind  = SW_SCROLL;
                                    n_after        = ST_TAB;
                                    n_state        = ST_SWEEP;
                                end
                            end
                            default: begin
                                o_cmd.cur_op = CUR_ADVANCE;
                                o_cmd.wr_sel = WR_CHAR;
                                if (scroll_on_advance) begin
                                    o_cmd.sw_start = 1'b1;
                                    o_cmd.sw_kind  = SW_SCROLL;
                                    n_after        = ST_DONE;
                                    n_state        = ST_SWEEP;
                                end
                            end
                        endcase
                    end
                    CMD_READ: begin
                        o_cmd.rd_cell = i_status.rd_in_range;
                    end
                    CMD_CLEAR: begin
                        o_cmd.cur_op   = CUR_HOME;
                        o_cmd.sw_start = 1'b1;
                        o_cmd.sw_kind  = SW_CLEAR;
                        n_after        = ST_DONE;
                        n_state        = ST_SWEEP;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_TAB: begin
                // Keep writing spaces until the column reaches a tab stop.
                if (i_status.tab_aligned) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.cur_op = CUR_ADVANCE;
                    o_cmd.wr_sel = WR_SPACE_HERE;
                    if (scroll_on_advance) begin
                        o_cmd.sw_start = 1'b1;
                        o_cmd.sw_kind  = SW_SCROLL;
                        n_after        = ST_TAB;
                        n_state        = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                if (!i_status.sweep_busy) begin
                    n_state = r_after;
                end
            end
            ST_DONE: begin
                o_cmd.capture = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[src/tcw_dpath.sv]
// ----------------------------------------------------------------------------
// Text console writer datapath
// Holds the cursor, the text attribute, the cell memory with its sweep
// engine, the latched item and the result registers.
// ----------------------------------------------------------------------------
module tcw_dpath #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcw_pkg::t_dp_cmd    i_cmd,
    output tcw_pkg::t_dp_status o_status,
    input  logic [1:0]          i_command,
    input  logic [7:0]          i_char_code,
    input  logic [6:0]          i_read_col,
    input  logic [4:0]          i_read_row,
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_data,
    output logic                o_strobe,
    output logic [15:0]         o_cell_word,
    output logic [6:0]          o_cursor_col,
    output logic [4:0]          o_cursor_row,
    output logic [10:0]         o_cursor_linear
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int TP_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [TP_W-1:0]   TP_LAST   = TP_W'(TAB_STOP - 1);
    localparam logic [ADDR_W-1:0] IDX_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(COLUMNS);

    // Cursor, tab phase and attribute.
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [TP_W-1:0]   r_phase;
    logic [7:0]        r_attr;

    // Latched item.
    logic [1:0]        r_item_cmd;
    logic [7:0]        r_item_chr;
    logic [6:0]        r_rd_col;
    logic [4:0]        r_rd_row;

    // Cell memory and its ports.
    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Sweep engine: one cell per cycle, each write follows its read in the next cycle.
    logic              r_sw_active;
    logic [ADDR_W-1:0] r_sw_idx;
    t_sw_kind          r_sw_kind;
    logic              r_sw_wr_valid;
    logic [ADDR_W-1:0] r_sw_wr_addr;
    logic              r_sw_wr_copy;
    logic              sw_copy_now;

    // Result registers.
    logic              r_strobe;
    logic [15:0]       r_cell_word;
    logic [6:0]        r_out_col;
    logic [4:0]        r_out_row;
    logic [10:0]       r_out_linear;

    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_in_range;
    logic [15:0]       blank_word;
    logic [7:0]        write_char;
    t_chr_class        chr_class;

    // Linear addresses of the cursor and of the requested read cell.
    assign cur_addr    = ADDR_W'(r_row) * ROW_PITCH + ADDR_W'(r_col);
    assign rd_addr     = ADDR_W'(r_rd_row) * ROW_PITCH + ADDR_W'(r_rd_col);
    assign rd_in_range = (int'(r_rd_col) < COLUMNS) && (int'(r_rd_row) < ROWS);

    // Character class decode.
    always_comb begin
        case (r_item_chr)
            CHAR_BS:  chr_class = CHR_BS;
            CHAR_TAB: chr_class = CHR_TAB;
            CHAR_LF:  chr_class = CHR_LF;
            CHAR_CR:  chr_class = CHR_CR;
            default:  chr_class = CHR_PLAIN;
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_status.item_cmd    = r_item_cmd;
        o_status.chr_class   = chr_class;
        o_status.rd_in_range = rd_in_range;
        o_status.col_zero    = (r_col == '0);
        o_status.col_last    = (r_col == COL_LAST);
        o_status.row_last    = (r_row == ROW_LAST);
        o_status.tab_aligned = (r_phase == '0);
        o_status.sweep_busy  = r_sw_active || r_sw_wr_valid;
    end

    // Attribute register, written by the configuration channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    // Item latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item_cmd <= i_command;
            r_item_chr <= i_char_code;
            r_rd_col   <= i_read_col;
            r_rd_row   <= i_read_row;
        end
    end

    // Cursor update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else begin
            case (i_cmd.cur_op)
                CUR_ADVANCE: begin
                    if (r_col == COL_LAST) begin
                        r_col   <= '0;
                        r_phase <= '0;
                        if (r_row != ROW_LAST) begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_phase <= (r_phase == TP_LAST) ? '0 : r_phase + 1'b1;
                    end
                end
                CUR_NEWLINE: begin
                    r_col   <= '0;
                    r_phase <= '0;
                    if (r_row != ROW_LAST) begin
                        r_row <= r_row + 1'b1;
                    end
                end
                CUR_RETURN: begin
                    r_col   <= '0;
                    r_phase <= '0;
                end
                CUR_BACK: begin
                    r_col   <= r_col - 1'b1;
                    r_phase <= (r_phase == '0) ? TP_LAST : r_phase - 1'b1;
                end
                CUR_HOME: begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_phase <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Sweep counter and the trailing write slot.
    assign sw_copy_now = (r_sw_kind == SW_SCROLL) && (r_sw_idx < COPY_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_active   <= 1'b0;
            r_sw_wr_valid <= 1'b0;
            r_sw_idx      <= '0;
            r_sw_kind     <= SW_INIT;
        end else begin
            r_sw_wr_valid <= r_sw_active;
            if (i_cmd.sw_start) begin
                r_sw_active <= 1'b1;
                r_sw_idx    <= '0;
                r_sw_kind   <= i_cmd.sw_kind;
            end else if (r_sw_active) begin
                r_sw_idx <= r_sw_idx + 1'b1;
                if (r_sw_idx == IDX_LAST) begin
                    r_sw_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw_wr_addr <= r_sw_idx;
        r_sw_wr_copy <= sw_copy_now;
    end

    // Blank cell: a space with the attribute in force for this sweep.
    assign blank_word = (r_sw_kind == SW_INIT) ? {ATTR_RESET, CHAR_SPACE}
                                               : {r_attr, CHAR_SPACE};
    assign write_char = (i_cmd.wr_sel == WR_CHAR) ? r_item_chr : CHAR_SPACE;

    // Memory write port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = {r_attr, write_char};
        if (r_sw_wr_valid) begin
            mem_we    = 1'b1;
            mem_waddr = r_sw_wr_addr;
            mem_wdata = r_sw_wr_copy ? r_rdata : blank_word;
        end else if (i_cmd.wr_sel != WR_NONE) begin
            mem_we = 1'b1;
            if (i_cmd.wr_sel == WR_SPACE_PREV) begin
                mem_waddr = cur_addr - 1'b1;
            end
        end
    end

    // Memory read port selection: a row below during a scroll, else the item.
    always_comb begin
        if (r_sw_active && sw_copy_now) begin
            mem_re    = 1'b1;
            mem_raddr = r_sw_idx + ROW_PITCH;
        end else begin
            mem_re    = i_cmd.rd_cell;
            mem_raddr = rd_addr;
        end
    end

    // Cell memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.capture;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cell_word  <= ((r_item_cmd == CMD_READ) && rd_in_range) ? r_rdata : '0;
            r_out_col    <= 7'(r_col);
            r_out_row    <= 5'(r_row);
            r_out_linear <= 11'(cur_addr);
        end
    end

    assign o_strobe        = r_strobe;
    assign o_cell_word     = r_cell_word;
    assign o_cursor_col    = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_linear = r_out_linear;

endmodule

[src/text_console_writer.sv]
// ----------------------------------------------------------------------------
// Text console writer
// Character cell console with cursor handling, wrap, scroll, clear and read.
// ----------------------------------------------------------------------------
// Usage:
//   An item (command, char_code, read_col, read_row) is taken at a clock edge
//   with start high and busy low. Each item gives one result, shown for one
//   cycle with o_strobe high; the receiver cannot hold it off.
//   The attribute register is written through i_cfg_valid / i_cfg_data;
//   o_cfg_ready stays high, so every valid cycle is a transfer.
// Sequencing:
//   For plain characters, control characters, reads and unused commands
//   that start no sweep, the item passes DISPATCH and DONE; the strobe,
//   registered from DONE, comes with the block back in IDLE, so the next
//   item can be taken at the edge that ends that cycle. A tab writes a space
//   at each step until the column reaches a tab stop. A scroll or a clear
//   sweeps the whole cell memory through its single write port, one cell per cycle.
// Reset:
//   The cursor homes, the attribute returns to 07 hex, and a clearing pass
//   fills every cell with a space. busy is high during reset and until
//   the clearing pass has finished.
//   Configuration transfers are taken during the clearing pass.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_read_col,
    input  logic [4:0]  i_read_row,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [15:0] o_cell_word,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_linear
);
    import tcw_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // The attribute register accepts a write in any cycle out of reset.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // Cursor, cell memory and result registers.
    tcw_dpath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_command       (i_command),
        .i_char_code     (i_char_code),
        .i_read_col      (i_read_col),
        .i_read_row      (i_read_row),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_cell_word     (o_cell_word),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_linear (o_cursor_linear)
    );

endmodule

[src/tcw_checker.sv]
// ----------------------------------------------------------------------------
// Text console writer port checker
// Watches the top-level ports for command and result sequencing errors.
// ----------------------------------------------------------------------------
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [6:0]  o_cursor_col,
    input logic [4:0]  o_cursor_row,
    input logic [10:0] o_cursor_linear
);

    // A result is shown for a single cycle.
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after taking an item");

    // The result is delivered once the block is free again.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while still busy");

    // The linear cursor agrees with the row and column.
    a_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_cursor_linear ==
                      11'(int'(o_cursor_row) * COLUMNS + int'(o_cursor_col))))
        else $error("linear cursor does not match row and column");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS)
) u_tcw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_cursor_col    (o_cursor_col),
    .o_cursor_row    (o_cursor_row),
    .o_cursor_linear (o_cursor_linear)
);
